### hw/rtl/multitone_ook_modulator_macros.svh
// ----------------------------------------------------------------------------
// multitone ook modulator assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef MULTITONE_OOK_MODULATOR_MACROS_SVH
`define MULTITONE_OOK_MODULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define MOOK_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define MOOK_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### hw/rtl/mook_pkg.sv
// ----------------------------------------------------------------------------
// mook_pkg
// types, constants and the quarter-wave sine table of the ook modulator
// ----------------------------------------------------------------------------
package mook_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int TABLE_BITS    = $clog2(TABLE_ENTRIES);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [15:0] SINE_MAX    = 16'd32767;

   typedef logic [15:0] sine_table_type [TABLE_ENTRIES];
   typedef logic [63:0] divisor_type [5];

   // (2k)(2k+1) for k = 1..5
   localparam divisor_type TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

   // one tone contribution, already signed and gated
   typedef struct packed {
      logic signed [16:0] tone;
   } lane_out_type;

   // per-sample control riding along the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } ctrl_type;

   // odd taylor series through x^11 in q30, rounded to q15
   function automatic logic [15:0] series_sine(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      r;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 0; k < 5; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if ((k % 2) == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum * 32768 + (64'sd1 <<< 29)) >>> 30;
      if (r > 32767) begin
         r = 32767;
      end
      return r[15:0];
   endfunction

   function automatic sine_table_type build_table();
      sine_table_type t;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         t[i] = series_sine((HALF_PI_Q30 * 64'(i)) / TABLE_ENTRIES);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_table();

endpackage

### hw/rtl/mook_lane.sv
// ----------------------------------------------------------------------------
// mook_lane
// one tone lane: quadrant fold, quarter-wave lookup, sign and gating
// ----------------------------------------------------------------------------
module mook_lane
   import mook_pkg::*;
(
   input  logic         clock,
   input  logic         enable,
   input  logic [31:0]  phase,
   input  logic         tone_on,
   output lane_out_type lane_ff
);

   logic [1:0]            quad;
   logic [29:0]           frac;
   logic [30:0]           mirror;
   logic [TABLE_BITS:0]   idx;
   logic [15:0]           mag;
   logic signed [16:0]    signed_mag;
   lane_out_type          lane_in;

   assign quad   = phase[31:30];
   assign frac   = phase[29:0];
   assign mirror = (31'd1 << 30) - {1'b0, frac};

   always_comb begin
      if (quad[0]) begin
         idx = mirror[30 -: (TABLE_BITS + 1)];
      end else begin
         idx = {1'b0, frac[29 -: TABLE_BITS]};
      end
      // index one past the table is the crest of the wave
      if (idx[TABLE_BITS]) begin
         mag = SINE_MAX;
      end else begin
         mag = SINE_TABLE[idx[TABLE_BITS-1:0]];
      end
      signed_mag = $signed({1'b0, mag});
      if (!tone_on) begin
         lane_in.tone = '0;
      end else if (quad[1]) begin
         lane_in.tone = -signed_mag;
      end else begin
         lane_in.tone = signed_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

endmodule

### hw/rtl/mook_merge.sv
// ----------------------------------------------------------------------------
// mook_merge
// sums the lanes, halves toward zero, saturates and holds the output register
// ----------------------------------------------------------------------------
module mook_merge
   import mook_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  lane_out_type       lane_first,
   input  lane_out_type       lane_second,
   input  ctrl_type           ctrl,
   output logic               valid_ff,
   output logic signed [15:0] sample_ff,
   output logic               last_ff
);

   logic signed [17:0] sum;
   logic signed [17:0] half;
   logic signed [15:0] sample_in;

   always_comb begin
      sum  = 18'(lane_first.tone) + 18'(lane_second.tone);
      // bias negatives by one so the shift truncates toward zero
      half = (sum + $signed({17'd0, sum[17]})) >>> 1;
      if (half > 18'sd32767) begin
         sample_in = 16'sh7fff;
      end else if (half < -18'sd32768) begin
         sample_in = 16'sh8000;
      end else begin
         sample_in = half[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sample_ff <= sample_in;
         last_ff   <= ctrl.last;
      end
   end

endmodule

### hw/rtl/multitone_ook_modulator.sv
// ----------------------------------------------------------------------------
// multitone_ook_modulator
// two-tone on-off keying modulator, one bit pair in, SAMPLES_PER_BIT samples out
// pipeline: sequencer, lane and output registers, in that order
// throughput: one sample per cycle while the output is not stalled, SAMPLES_PER_BIT
//   samples per item; the next item is taken as the last sample issues
// reset: synchronous, clears phases, sequencer, pipeline valids and restores
//   the default phase steps; the sine table is constant logic
// ----------------------------------------------------------------------------
`include "multitone_ook_modulator_macros.svh"

module multitone_ook_modulator
   import mook_pkg::*;
#(
   parameter int SAMPLES_PER_BIT = 32
)
(
   input  logic               clock,
   input  logic               reset,
   // bit pair transactions
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_bit_first,
   input  logic               req_bit_second,
   // sample transactions
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last_of_bit,
   // register writes
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int CNT_W = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 1;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_BIT - 1);

   localparam logic CSR_PHASE_STEP_FIRST  = 1'b0;
   localparam logic CSR_PHASE_STEP_SECOND = 1'b1;

   localparam logic [31:0] STEP_FIRST_RESET  = 32'd93001833;
   localparam logic [31:0] STEP_SECOND_RESET = 32'd46500916;

   // configuration
   logic [31:0] step_first_ff,  step_first_in;
   logic [31:0] step_second_ff, step_second_in;

   // sequencer: current item and sample count
   logic             active_ff,  active_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic             on_first_ff,  on_first_in;
   logic             on_second_ff, on_second_in;
   logic [31:0]      phase_first_ff,  phase_first_in;
   logic [31:0]      phase_second_ff, phase_second_in;

   // lookup stage control
   ctrl_type     s1_ctrl_ff, s1_ctrl_in;
   lane_out_type lane_first, lane_second;

   logic advance;
   logic issue;
   logic issue_last;
   logic req_accept;

   // whole pipeline moves together unless a held sample is stalled
   assign advance    = !rsp_valid || !rsp_stall;
   assign issue      = active_ff && advance;
   assign issue_last = issue && (count_ff == LAST_COUNT);
   assign req_stall  = active_ff && !issue_last;
   assign req_accept = req_valid && !req_stall;

   // register writes
   always_comb begin
      step_first_in  = step_first_ff;
      step_second_in = step_second_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PHASE_STEP_FIRST:  step_first_in  = csr_write_data;
            CSR_PHASE_STEP_SECOND: step_second_in = csr_write_data;
            default:               step_first_in  = step_first_ff;
         endcase
      end
   end

   // sample sequencer
   always_comb begin
      active_in       = active_ff;
      count_in        = count_ff;
      on_first_in     = on_first_ff;
      on_second_in    = on_second_ff;
      phase_first_in  = phase_first_ff;
      phase_second_in = phase_second_ff;
      if (issue) begin
         // both phases run whether or not the tone is keyed
         phase_first_in  = phase_first_ff + step_first_ff;
         phase_second_in = phase_second_ff + step_second_ff;
         count_in        = count_ff + CNT_W'(1);
         if (issue_last) begin
            active_in = 1'b0;
         end
      end
      if (req_accept) begin
         active_in    = 1'b1;
         count_in     = '0;
         on_first_in  = req_bit_first;
         on_second_in = req_bit_second;
      end
   end

   always_comb begin
      s1_ctrl_in = s1_ctrl_ff;
      if (advance) begin
         s1_ctrl_in.valid = issue;
         s1_ctrl_in.last  = issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_first_ff   <= STEP_FIRST_RESET;
         step_second_ff  <= STEP_SECOND_RESET;
         active_ff       <= 1'b0;
         count_ff        <= '0;
         phase_first_ff  <= '0;
         phase_second_ff <= '0;
         s1_ctrl_ff      <= '0;
      end else begin
         step_first_ff   <= step_first_in;
         step_second_ff  <= step_second_in;
         active_ff       <= active_in;
         count_ff        <= count_in;
         phase_first_ff  <= phase_first_in;
         phase_second_ff <= phase_second_in;
         s1_ctrl_ff      <= s1_ctrl_in;
      end
   end

   // keying bits are payload
   always_ff @(posedge clock) begin
      on_first_ff  <= on_first_in;
      on_second_ff <= on_second_in;
   end

   // one lane per tone
   mook_lane u_lane_first (
      .clock   (clock),
      .enable  (advance),
      .phase   (phase_first_ff),
      .tone_on (on_first_ff),
      .lane_ff (lane_first)
   );

   mook_lane u_lane_second (
      .clock   (clock),
      .enable  (advance),
      .phase   (phase_second_ff),
      .tone_on (on_second_ff),
      .lane_ff (lane_second)
   );

   // combine tones into the output register
   mook_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .lane_first  (lane_first),
      .lane_second (lane_second),
      .ctrl        (s1_ctrl_ff),
      .valid_ff    (rsp_valid),
      .sample_ff   (rsp_sample),
      .last_ff     (rsp_last_of_bit)
   );

   // a new transaction always starts its bit period at sample zero
   `MOOK_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept,
                     active_ff && (count_ff == '0),
                     "accepted transaction did not start at sample zero")
   // the last sample ends the item unless another is taken in the same cycle
   `MOOK_ASSERT_NEXT(a_last_ends, clock, reset, issue_last && !req_accept,
                     !active_ff,
                     "sequencer stayed busy after last sample")
   // a sample in the lookup stage reaches the output when the pipe moves
   `MOOK_ASSERT_NEXT(a_lookup_to_out, clock, reset, s1_ctrl_ff.valid && advance,
                     rsp_valid && (rsp_last_of_bit == $past(s1_ctrl_ff.last)),
                     "lookup stage sample lost")
   // no sample issues while the output holds a stalled one
   `MOOK_ASSERT_IMPLY(a_no_issue_stalled, clock, reset, rsp_valid && rsp_stall,
                      !issue,
                      "sample issued while output stalled")

endmodule
